>>> rtl/fcd_pkg.sv
`default_nettype none

package fcd_pkg;

   // Message and font geometry.
   localparam int unsigned MESSAGE_CHARS   = 15;
   localparam int unsigned QUEUE_DEPTH_DEF = 4;
   localparam int unsigned CHAR_W          = 8;
   localparam int unsigned SLOT_W          = 4;
   localparam int unsigned GLYPH_COLS      = 5;
   localparam int unsigned GLYPH_ROWS      = 7;
   localparam int unsigned GLYPH_BITS      = GLYPH_COLS * GLYPH_ROWS;
   localparam int unsigned SUBPANEL_COLS   = 25;

   localparam logic [7:0] GLYPH_FIRST = 8'd32;
   localparam logic [7:0] GLYPH_LAST  = 8'd126;

   // Codes carried in the command bytes.
   localparam logic [1:0] FLAG_SET     = 2'd1;
   localparam logic [1:0] FLAG_CLEAR   = 2'd2;
   localparam logic [1:0] MUX_SEL_LAST = 2'd3;
   localparam logic [2:0] MUX_COL_LAST = 3'd7;
   localparam logic [2:0] ROW_LAST     = 3'd6;
   localparam logic [2:0] COL_LAST     = 3'd4;
   localparam logic [4:0] WITHIN_LAST  = 5'd24;

   typedef logic [GLYPH_BITS-1:0] glyph_type;

   // One queued character as it sits in the input memory.
   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic [SLOT_W-1:0] slot;
   } req_word_type;

   // Status the queue hands to the dot generator.
   typedef struct packed {
      logic         nonempty;
      req_word_type rd_word;
   } queue_stat_type;

   // Maps a character code onto a font entry; unprintable codes show blank.
   function automatic logic [6:0] glyph_index(input logic [7:0] code);
      logic [7:0] offs;
      offs = code - GLYPH_FIRST;
      if (code inside {[GLYPH_FIRST:GLYPH_LAST]}) begin
         glyph_index = offs[6:0];
      end else begin
         glyph_index = 7'd0;
      end
   endfunction

   // Font table: five columns, column 0 in the top bits, row 0 is bit 6 of a column.
   function automatic glyph_type font_glyph(input logic [6:0] idx);
      glyph_type g;
      case (idx)
         7'd0:  g = {7'd0, 7'd0, 7'd0, 7'd0, 7'd0};
         7'd1:  g = {7'd0, 7'd56, 7'd125, 7'd56, 7'd0};
         7'd2:  g = {7'd80, 7'd96, 7'd0, 7'd80, 7'd96};
         7'd3:  g = {7'd20, 7'd127, 7'd20, 7'd127, 7'd20};
         7'd4:  g = {7'd18, 7'd42, 7'd127, 7'd42, 7'd36};
         7'd5:  g = {7'd98, 7'd100, 7'd8, 7'd19, 7'd35};
         7'd6:  g = {7'd54, 7'd73, 7'd85, 7'd34, 7'd5};
         7'd7:  g = {7'd0, 7'd80, 7'd96, 7'd0, 7'd0};
         7'd8:  g = {7'd0, 7'd28, 7'd34, 7'd65, 7'd0};
         7'd9:  g = {7'd0, 7'd65, 7'd34, 7'd28, 7'd0};
         7'd10: g = {7'd20, 7'd8, 7'd62, 7'd8, 7'd20};
         7'd11: g = {7'd8, 7'd8, 7'd62, 7'd8, 7'd8};
         7'd12: g = {7'd0, 7'd5, 7'd6, 7'd0, 7'd0};
         7'd13: g = {7'd8, 7'd8, 7'd8, 7'd8, 7'd8};
         7'd14: g = {7'd0, 7'd3, 7'd3, 7'd0, 7'd0};
         7'd15: g = {7'd2, 7'd4, 7'd8, 7'd16, 7'd32};
         7'd16: g = {7'd62, 7'd69, 7'd73, 7'd81, 7'd62};
         7'd17: g = {7'd17, 7'd33, 7'd127, 7'd1, 7'd1};
         7'd18: g = {7'd33, 7'd67, 7'd69, 7'd73, 7'd49};
         7'd19: g = {7'd34, 7'd65, 7'd73, 7'd73, 7'd54};
         7'd20: g = {7'd12, 7'd20, 7'd36, 7'd127, 7'd4};
         7'd21: g = {7'd114, 7'd81, 7'd81, 7'd81, 7'd78};
         7'd22: g = {7'd62, 7'd73, 7'd73, 7'd73, 7'd38};
         7'd23: g = {7'd64, 7'd71, 7'd72, 7'd80, 7'd96};
         7'd24: g = {7'd54, 7'd73, 7'd73, 7'd73, 7'd54};
         7'd25: g = {7'd50, 7'd73, 7'd73, 7'd73, 7'd62};
         7'd26: g = {7'd0, 7'd54, 7'd54, 7'd0, 7'd0};
         7'd27: g = {7'd0, 7'd53, 7'd54, 7'd0, 7'd0};
         7'd28: g = {7'd8, 7'd20, 7'd34, 7'd65, 7'd0};
         7'd29: g = {7'd20, 7'd20, 7'd20, 7'd20, 7'd20};
         7'd30: g = {7'd0, 7'd65, 7'd34, 7'd20, 7'd8};
         7'd31: g = {7'd32, 7'd64, 7'd69, 7'd72, 7'd48};
         7'd32: g = {7'd62, 7'd73, 7'd87, 7'd85, 7'd62};
         7'd33: g = {7'd31, 7'd36, 7'd68, 7'd36, 7'd31};
         7'd34: g = {7'd127, 7'd73, 7'd73, 7'd73, 7'd54};
         7'd35: g = {7'd62, 7'd65, 7'd65, 7'd65, 7'd34};
         7'd36: g = {7'd127, 7'd65, 7'd65, 7'd34, 7'd28};
         7'd37: g = {7'd127, 7'd73, 7'd73, 7'd65, 7'd65};
         7'd38: g = {7'd127, 7'd72, 7'd72, 7'd72, 7'd64};
         7'd39: g = {7'd62, 7'd65, 7'd65, 7'd69, 7'd38};
         7'd40: g = {7'd127, 7'd8, 7'd8, 7'd8, 7'd127};
         7'd41: g = {7'd0, 7'd65, 7'd127, 7'd65, 7'd0};
         7'd42: g = {7'd2, 7'd1, 7'd1, 7'd1, 7'd126};
         7'd43: g = {7'd127, 7'd8, 7'd20, 7'd34, 7'd65};
         7'd44: g = {7'd127, 7'd1, 7'd1, 7'd1, 7'd1};
         7'd45: g = {7'd127, 7'd32, 7'd16, 7'd32, 7'd127};
         7'd46: g = {7'd127, 7'd32, 7'd16, 7'd8, 7'd127};
         7'd47: g = {7'd62, 7'd65, 7'd65, 7'd65, 7'd62};
         7'd48: g = {7'd127, 7'd72, 7'd72, 7'd72, 7'd48};
         7'd49: g = {7'd62, 7'd65, 7'd69, 7'd66, 7'd61};
         7'd50: g = {7'd127, 7'd72, 7'd76, 7'd74, 7'd49};
         7'd51: g = {7'd50, 7'd73, 7'd73, 7'd73, 7'd38};
         7'd52: g = {7'd64, 7'd64, 7'd127, 7'd64, 7'd64};
         7'd53: g = {7'd126, 7'd1, 7'd1, 7'd1, 7'd126};
         7'd54: g = {7'd124, 7'd2, 7'd1, 7'd2, 7'd124};
         7'd55: g = {7'd126, 7'd1, 7'd6, 7'd1, 7'd126};
         7'd56: g = {7'd99, 7'd20, 7'd8, 7'd20, 7'd99};
         7'd57: g = {7'd96, 7'd16, 7'd15, 7'd16, 7'd96};
         7'd58: g = {7'd67, 7'd69, 7'd73, 7'd81, 7'd97};
         7'd59: g = {7'd0, 7'd127, 7'd65, 7'd65, 7'd0};
         7'd60: g = {7'd32, 7'd16, 7'd8, 7'd4, 7'd2};
         7'd61: g = {7'd0, 7'd65, 7'd65, 7'd127, 7'd0};
         7'd62: g = {7'd16, 7'd32, 7'd64, 7'd32, 7'd16};
         7'd63: g = {7'd1, 7'd1, 7'd1, 7'd1, 7'd1};
         7'd64: g = {7'd0, 7'd64, 7'd32, 7'd16, 7'd0};
         7'd65: g = {7'd2, 7'd21, 7'd21, 7'd14, 7'd1};
         7'd66: g = {7'd64, 7'd126, 7'd9, 7'd17, 7'd14};
         7'd67: g = {7'd14, 7'd17, 7'd17, 7'd17, 7'd10};
         7'd68: g = {7'd14, 7'd17, 7'd74, 7'd127, 7'd1};
         7'd69: g = {7'd14, 7'd21, 7'd21, 7'd21, 7'd9};
         7'd70: g = {7'd1, 7'd9, 7'd63, 7'd72, 7'd32};
         7'd71: g = {7'd9, 7'd21, 7'd21, 7'd21, 7'd30};
         7'd72: g = {7'd127, 7'd8, 7'd8, 7'd8, 7'd7};
         7'd73: g = {7'd0, 7'd0, 7'd46, 7'd1, 7'd1};
         7'd74: g = {7'd2, 7'd1, 7'd1, 7'd1, 7'd94};
         7'd75: g = {7'd1, 7'd127, 7'd4, 7'd10, 7'd17};
         7'd76: g = {7'd0, 7'd65, 7'd127, 7'd1, 7'd0};
         7'd77: g = {7'd31, 7'd16, 7'd14, 7'd16, 7'd31};
         7'd78: g = {7'd31, 7'd8, 7'd16, 7'd16, 7'd15};
         7'd79: g = {7'd14, 7'd17, 7'd17, 7'd17, 7'd14};
         7'd80: g = {7'd127, 7'd20, 7'd20, 7'd20, 7'd8};
         7'd81: g = {7'd8, 7'd20, 7'd20, 7'd31, 7'd1};
         7'd82: g = {7'd31, 7'd8, 7'd16, 7'd16, 7'd8};
         7'd83: g = {7'd9, 7'd21, 7'd21, 7'd21, 7'd18};
         7'd84: g = {7'd16, 7'd16, 7'd126, 7'd17, 7'd18};
         7'd85: g = {7'd30, 7'd1, 7'd1, 7'd30, 7'd1};
         7'd86: g = {7'd28, 7'd2, 7'd1, 7'd2, 7'd28};
         7'd87: g = {7'd30, 7'd1, 7'd6, 7'd1, 7'd30};
         7'd88: g = {7'd17, 7'd10, 7'd4, 7'd10, 7'd17};
         7'd89: g = {7'd16, 7'd9, 7'd6, 7'd8, 7'd16};
         7'd90: g = {7'd17, 7'd19, 7'd21, 7'd25, 7'd17};
         7'd91: g = {7'd8, 7'd54, 7'd65, 7'd65, 7'd0};
         7'd92: g = {7'd0, 7'd0, 7'd127, 7'd0, 7'd0};
         7'd93: g = {7'd0, 7'd65, 7'd65, 7'd54, 7'd8};
         7'd94: g = {7'd32, 7'd64, 7'd32, 7'd16, 7'd32};
         default: g = '0;
      endcase
      font_glyph = g;
   endfunction

endpackage

`default_nettype wire

>>> rtl/fcd_req_if.sv
`default_nettype none

// Character channel: one word is a character code and its message slot.
interface fcd_req_if;
   import fcd_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, output char_code, output slot, input ready);
   modport sink   (input valid, input char_code, input slot, output ready);
endinterface

`default_nettype wire

>>> rtl/fcd_rsp_if.sv
`default_nettype none

// Dot command channel: one word drives a single dot of the sign.
interface fcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] column_code;
   logic [7:0] row_code;
   logic       dot_on;
   logic       last_dot;

   modport source (output valid, output column_code, output row_code, output dot_on,
                   output last_dot, input ready);
   modport sink   (input valid, input column_code, input row_code, input dot_on,
                   input last_dot, output ready);
endinterface

`default_nettype wire

>>> rtl/flipdot_character_dot_commands.sv
// The first dot command of a character passes the queue RAM, the staging
// register, the active register and the output register after the character
// word is accepted. The single dot walker sends one dot command per cycle while
// the receiver is ready; up to QUEUE_DEPTH characters wait in the input RAM.
// Reset: synchronous, clears the queue pointers and all valid flags; no
// clearing pass. Characters with a slot beyond the message are taken and dropped.
`default_nettype none

module flipdot_character_dot_commands
   import fcd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   fcd_req_if.sink   req_ch,
   fcd_rsp_if.source rsp_ch
);

   logic           full;
   logic           push;
   logic           pop;
   req_word_type   push_word;
   queue_stat_type stat;

   // Only characters that fall inside the message are queued.
   assign req_ch.ready = !full;
   assign push = req_ch.valid && !full && (req_ch.slot < SLOT_W'(MESSAGE_CHARS));
   assign push_word.char_code = req_ch.char_code;
   assign push_word.slot      = req_ch.slot;

   fcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (full),
      .pop       (pop),
      .stat      (stat)
   );

   fcd_dot_gen u_dot_gen (
      .clock  (clock),
      .reset  (reset),
      .stat   (stat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

>>> rtl/fcd_ram.sv
`default_nettype none

// Simple dual-port RAM with one write port and a registered read port.
module fcd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/fcd_queue.sv
`default_nettype none

// Character queue held in a RAM. A pop presents its word in the following cycle.
module fcd_queue
   import fcd_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire req_word_type   push_word,
   output      logic           full,
   input  wire logic           pop,
   output queue_stat_type      stat
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned WORD_W = $bits(req_word_type);

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop_ok;
   logic [WORD_W-1:0] rd_bits;

   assign full   = (count_ff == CNT_W'(DEPTH));
   assign pop_ok = pop && (count_ff != '0);

   // Pointer and fill count update; the pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop_ok})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // A pop only reads an entry written in an earlier cycle, so the read
   // never collides with the write at the same address.
   fcd_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ptr_ff),
      .wr_data (push_word),
      .rd_en   (pop_ok),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_bits)
   );

   assign stat.nonempty = (count_ff != '0);
   assign stat.rd_word  = rd_bits;

endmodule

`default_nettype wire

>>> rtl/fcd_dot_gen.sv
`default_nettype none

// Pulls characters from the queue and walks their 35 dots, one per cycle while the output is not stalled.
module fcd_dot_gen
   import fcd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire queue_stat_type stat,
   output      logic           pop,
   fcd_rsp_if.source           rsp_ch
);

   // Queue read in flight.
   logic fetch_ff;

   // Next character, staged while the current one is emitted.
   logic       nxt_vld_ff, nxt_vld_in;
   glyph_type  nxt_bits_ff;
   logic [1:0] nxt_panel_ff;
   logic [4:0] nxt_within_ff;

   // Character being emitted.
   logic       act_vld_ff, act_vld_in;
   glyph_type  act_bits_ff, act_bits_in;
   logic [2:0] row_ff, row_in;
   logic [2:0] gcol_ff, gcol_in;
   logic [1:0] panel_ff, panel_in;
   logic [4:0] within_ff, within_in;

   // Output register.
   logic       out_vld_ff;
   logic [7:0] column_code_ff;
   logic [7:0] row_code_ff;
   logic       dot_on_ff;
   logic       last_dot_ff;

   logic       advance, step, last, load;
   logic [6:0] start_col;
   logic [1:0] start_panel;
   logic [4:0] start_within;
   logic [1:0] mux_sel;
   logic [2:0] mux_col;

   assign pop     = stat.nonempty && !fetch_ff && !nxt_vld_ff;
   assign advance = !out_vld_ff || rsp_ch.ready;
   assign step    = act_vld_ff && advance;
   assign last    = (gcol_ff == COL_LAST) && (row_ff == ROW_LAST);
   assign load    = nxt_vld_ff && (!act_vld_ff || (step && last));

   // First display column of the slot split into subpanel and offset.
   always_comb begin
      start_col = 7'(stat.rd_word.slot) * 7'(GLYPH_COLS);
      if (start_col >= 7'(2 * SUBPANEL_COLS)) begin
         start_panel  = 2'd2;
         start_within = 5'(start_col - 7'(2 * SUBPANEL_COLS));
      end else if (start_col >= 7'(SUBPANEL_COLS)) begin
         start_panel  = 2'd1;
         start_within = 5'(start_col - 7'(SUBPANEL_COLS));
      end else begin
         start_panel  = 2'd0;
         start_within = start_col[4:0];
      end
   end

   // Staging register is filled by a queue read and emptied by a load.
   always_comb begin
      nxt_vld_in = nxt_vld_ff;
      if (fetch_ff) begin
         nxt_vld_in = 1'b1;
      end else if (load) begin
         nxt_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_ff   <= 1'b0;
         nxt_vld_ff <= 1'b0;
      end else begin
         fetch_ff   <= pop;
         nxt_vld_ff <= nxt_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_ff) begin
         nxt_bits_ff   <= font_glyph(glyph_index(stat.rd_word.char_code));
         nxt_panel_ff  <= start_panel;
         nxt_within_ff <= start_within;
      end
   end

   // Dot walk: rows inside columns, moving to the next display column
   // after the bottom row.
   always_comb begin
      act_vld_in  = act_vld_ff;
      act_bits_in = act_bits_ff;
      row_in      = row_ff;
      gcol_in     = gcol_ff;
      panel_in    = panel_ff;
      within_in   = within_ff;
      if (load) begin
         act_vld_in  = 1'b1;
         act_bits_in = nxt_bits_ff;
         row_in      = '0;
         gcol_in     = '0;
         panel_in    = nxt_panel_ff;
         within_in   = nxt_within_ff;
      end else if (step) begin
         act_vld_in  = !last;
         act_bits_in = {act_bits_ff[GLYPH_BITS-2:0], 1'b0};
         if (row_ff == ROW_LAST) begin
            row_in  = '0;
            gcol_in = gcol_ff + 1'b1;
            if (within_ff == WITHIN_LAST) begin
               within_in = '0;
               panel_in  = panel_ff + 1'b1;
            end else begin
               within_in = within_ff + 1'b1;
            end
         end else begin
            row_in = row_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_vld_ff <= 1'b0;
      end else begin
         act_vld_ff <= act_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      act_bits_ff <= act_bits_in;
      row_ff      <= row_in;
      gcol_ff     <= gcol_in;
      panel_ff    <= panel_in;
      within_ff   <= within_in;
   end

   // Multiplexer addressing; the last column of a subpanel has its own select.
   always_comb begin
      if (within_ff == WITHIN_LAST) begin
         mux_sel = MUX_SEL_LAST;
         mux_col = MUX_COL_LAST;
      end else begin
         mux_sel = within_ff[4:3];
         mux_col = within_ff[2:0];
      end
   end

   // Output register, refilled whenever it is empty or being taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= step;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         column_code_ff <= {mux_col, mux_sel, panel_ff, 1'b0};
         row_code_ff    <= {row_ff, act_bits_ff[GLYPH_BITS-1] ? FLAG_SET : FLAG_CLEAR, 3'b000};
         dot_on_ff      <= act_bits_ff[GLYPH_BITS-1];
         last_dot_ff    <= last;
      end
   end

   assign rsp_ch.valid       = out_vld_ff;
   assign rsp_ch.column_code = column_code_ff;
   assign rsp_ch.row_code    = row_code_ff;
   assign rsp_ch.dot_on      = dot_on_ff;
   assign rsp_ch.last_dot    = last_dot_ff;

endmodule

`default_nettype wire

>>> rtl/fcd_checker.sv
`default_nettype none

// Port-level checks on the dot command stream.
module fcd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_column_code,
   input wire logic [7:0] rsp_row_code,
   input wire logic       rsp_dot_on,
   input wire logic       rsp_last_dot
);

   // A stalled word stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_column_code)
         && $stable(rsp_row_code) && $stable(rsp_dot_on) && $stable(rsp_last_dot))
      else $error("dot command changed while stalled");

   // The set/clear flag follows the pixel value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_dot_on ? (rsp_row_code[4:3] == 2'd1) : (rsp_row_code[4:3] == 2'd2))
         && (rsp_row_code[2:0] == 3'd0))
      else $error("row flag does not match pixel");

   // The last column of a subpanel is addressed as select 3, column 7.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_column_code[4:3] == 2'd3) |-> (rsp_column_code[7:5] == 3'd7)
         && (rsp_column_code[0] == 1'b0))
      else $error("bad addressing of the last subpanel column");

   // The last command of a character is the bottom row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_dot |-> (rsp_row_code[7:5] == 3'd6))
      else $error("last dot is not on the bottom row");

endmodule

bind flipdot_character_dot_commands fcd_checker u_fcd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_column_code (rsp_ch.column_code),
   .rsp_row_code    (rsp_ch.row_code),
   .rsp_dot_on      (rsp_ch.dot_on),
   .rsp_last_dot    (rsp_ch.last_dot)
);

`default_nettype wire

>>> tb/tb_flipdot_character_dot_commands.sv
`default_nettype none

module tb_flipdot_character_dot_commands;
   timeunit 1ns;
   timeprecision 1ps;
   import fcd_pkg::*;

   // A run fails if no word moves on either channel for this many cycles.
   localparam int unsigned IDLE_LIMIT      = 2000;
   localparam int unsigned TAIL_CYCLES     = 40;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned FONT_GLYPHS     = 95;

   // One dot command as it leaves the block.
   typedef struct packed {
      logic [7:0] column_code;
      logic [7:0] row_code;
      logic       dot_on;
      logic       last_dot;
   } dot_cmd_type;

   // Font columns, five per glyph starting at space; row 0 is bit 6 of a column.
   localparam byte unsigned FONT_COLUMNS [FONT_GLYPHS*5] = '{
      0,0,0,0,0,          0,56,125,56,0,      80,96,0,80,96,      20,127,20,127,20,
      18,42,127,42,36,    98,100,8,19,35,     54,73,85,34,5,      0,80,96,0,0,
      0,28,34,65,0,       0,65,34,28,0,       20,8,62,8,20,       8,8,62,8,8,
      0,5,6,0,0,          8,8,8,8,8,          0,3,3,0,0,          2,4,8,16,32,
      62,69,73,81,62,     17,33,127,1,1,      33,67,69,73,49,     34,65,73,73,54,
      12,20,36,127,4,     114,81,81,81,78,    62,73,73,73,38,     64,71,72,80,96,
      54,73,73,73,54,     50,73,73,73,62,     0,54,54,0,0,        0,53,54,0,0,
      8,20,34,65,0,       20,20,20,20,20,     0,65,34,20,8,       32,64,69,72,48,
      62,73,87,85,62,     31,36,68,36,31,     127,73,73,73,54,    62,65,65,65,34,
      127,65,65,34,28,    127,73,73,65,65,    127,72,72,72,64,    62,65,65,69,38,
      127,8,8,8,127,      0,65,127,65,0,      2,1,1,1,126,        127,8,20,34,65,
      127,1,1,1,1,        127,32,16,32,127,   127,32,16,8,127,    62,65,65,65,62,
      127,72,72,72,48,    62,65,69,66,61,     127,72,76,74,49,    50,73,73,73,38,
      64,64,127,64,64,    126,1,1,1,126,      124,2,1,2,124,      126,1,6,1,126,
      99,20,8,20,99,      96,16,15,16,96,     67,69,73,81,97,     0,127,65,65,0,
      32,16,8,4,2,        0,65,65,127,0,      16,32,64,32,16,     1,1,1,1,1,
      0,64,32,16,0,       2,21,21,14,1,       64,126,9,17,14,     14,17,17,17,10,
      14,17,74,127,1,     14,21,21,21,9,      1,9,63,72,32,       9,21,21,21,30,
      127,8,8,8,7,        0,0,46,1,1,         2,1,1,1,94,         1,127,4,10,17,
      0,65,127,1,0,       31,16,14,16,31,     31,8,16,16,15,      14,17,17,17,14,
      127,20,20,20,8,     8,20,20,31,1,       31,8,16,16,8,       9,21,21,21,18,
      16,16,126,17,18,    30,1,1,30,1,        28,2,1,2,28,        30,1,6,1,30,
      17,10,4,10,17,      16,9,6,8,16,        17,19,21,25,17,     8,54,65,65,0,
      0,0,127,0,0,        0,65,65,54,8,       32,64,32,16,32
   };

   logic clock = 1'b0;
   logic reset;

   fcd_req_if req_ch ();
   fcd_rsp_if rsp_ch ();

   flipdot_character_dot_commands dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // Dot commands still owed by the block, oldest first.
   dot_cmd_type pending_dots [$];

   int unsigned n_errors  = 0;
   int unsigned n_chars   = 0;
   int unsigned n_dropped = 0;
   int unsigned n_dots    = 0;
   int unsigned n_lit     = 0;

   // Pacing controls shared by the tests, the send task and the receiver pacing process.
   bit          src_gaps     = 1'b0;
   bit          sink_stalls  = 1'b0;
   int unsigned hold_off_len = 0;

   // Work out the 35 dot commands a character in the message causes and queue them.
   function automatic void predict_dots(input logic [7:0] code, input logic [3:0] slot);
      int unsigned glyph;
      int unsigned col;
      int unsigned sub_col;
      logic [1:0]  panel;
      logic [1:0]  mux_sel;
      logic [2:0]  mux_col;
      logic [6:0]  bits;
      dot_cmd_type d;

      if (slot >= MESSAGE_CHARS) begin
         n_dropped++;
         return;
      end
      n_chars++;
      glyph = (code >= GLYPH_FIRST && code <= GLYPH_LAST) ? int'(code - GLYPH_FIRST) : 0;

      for (int c = 0; c < GLYPH_COLS; c++) begin
         col     = slot * GLYPH_COLS + c;
         sub_col = col % SUBPANEL_COLS;
         panel   = 2'(col / SUBPANEL_COLS);
         // The 25th column of a subpanel sits on its own select line.
         if (sub_col == SUBPANEL_COLS - 1) begin
            mux_sel = MUX_SEL_LAST;
            mux_col = MUX_COL_LAST;
         end else begin
            mux_sel = 2'(sub_col / 8);
            mux_col = 3'(sub_col % 8);
         end
         bits = FONT_COLUMNS[glyph * GLYPH_COLS + c][6:0];
         for (int r = 0; r < GLYPH_ROWS; r++) begin
            d.column_code = {mux_col, mux_sel, panel, 1'b0};
            d.dot_on      = bits[6 - r];
            d.row_code    = {3'(r), d.dot_on ? FLAG_SET : FLAG_CLEAR, 3'b000};
            d.last_dot    = (c == GLYPH_COLS - 1) && (r == GLYPH_ROWS - 1);
            pending_dots.push_back(d);
         end
      end
   endfunction

   // Offer one character word, with an occasional gap first when src_gaps is set, and wait until it is taken.
   task automatic send_char(input logic [7:0] code, input logic [3:0] slot);
      if (src_gaps && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= code;
      req_ch.slot      <= slot;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_dots(code, slot);
   endtask

   // Mostly printable text, with a share of arbitrary codes.
   function automatic logic [7:0] pick_code();
      if ($urandom_range(0, 5) == 0) begin
         return 8'($urandom_range(0, 255));
      end
      return 8'($urandom_range(GLYPH_FIRST, GLYPH_LAST));
   endfunction

   // Compare every dot command word with the oldest one still owed.
   always @(posedge clock) begin : check_dots
      dot_cmd_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_dots.size() == 0) begin
            $error("dot command word arrived with none expected");
            n_errors++;
         end else begin
            want = pending_dots.pop_front();
            n_dots++;
            if (want.dot_on) n_lit++;
            if (rsp_ch.column_code !== want.column_code) begin
               $error("column_code: expected %h, got %h", want.column_code, rsp_ch.column_code);
               n_errors++;
            end
            if (rsp_ch.row_code !== want.row_code) begin
               $error("row_code: expected %h, got %h", want.row_code, rsp_ch.row_code);
               n_errors++;
            end
            if (rsp_ch.dot_on !== want.dot_on) begin
               $error("dot_on: expected %b, got %b", want.dot_on, rsp_ch.dot_on);
               n_errors++;
            end
            if (rsp_ch.last_dot !== want.last_dot) begin
               $error("last_dot: expected %b, got %b", want.last_dot, rsp_ch.last_dot);
               n_errors++;
            end
         end
      end
   end

   // Receiver pacing: random stall bursts, ready stretches, and a long hold-off on request.
   initial begin : sink_pacing
      int unsigned span;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_len != 0) begin
            span         = hold_off_len;
            hold_off_len = 0;
            rsp_ch.ready <= 1'b0;
            repeat (span) @(posedge clock);
         end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            span = sink_stalls ? $urandom_range(1, 30) : 1;
            repeat (span) begin
               @(posedge clock);
               if (hold_off_len != 0) break;
            end
         end
      end
   end

   // End the run if neither channel moves a word for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Timed out after %0d cycles without progress.", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Glyph table ends, unprintable codes, subpanel edges, and slots past the message.
   task automatic test_glyph_extremes();
      src_gaps    = 1'b1;
      sink_stalls = 1'b1;
      send_char(8'd32, 4'd0);
      send_char(8'd126, 4'd14);
      send_char(8'd0, 4'd1);
      send_char(8'd31, 4'd2);
      send_char(8'd127, 4'd3);
      send_char(8'd255, 4'd4);
      send_char(8'd48, 4'd4);
      send_char(8'd65, 4'd9);
      send_char(8'd35, 4'd7);
      send_char(8'd64, 4'd10);
      send_char(8'd33, 4'd5);
      send_char(8'd95, 4'd13);
      send_char(8'd88, 4'd15);
      send_char(8'd255, 4'd15);
      send_char(8'd0, 4'd15);
      send_char(8'd87, 4'd8);
      send_char(8'd125, 4'd11);
      send_char(8'd72, 4'd12);
      send_char(8'd106, 4'd6);
   endtask

   // Random text in random slots, with gaps and stalls on both sides.
   task automatic test_random_text();
      logic [3:0] slot;
      src_gaps    = 1'b1;
      sink_stalls = 1'b1;
      repeat (140) begin
         slot = ($urandom_range(0, 15) == 0) ? 4'd15 : 4'($urandom_range(0, 14));
         send_char(pick_code(), slot);
      end
   endtask

   // The receiver holds off while characters keep coming, so the input queue fills.
   task automatic test_input_back_pressure();
      src_gaps     = 1'b0;
      sink_stalls  = 1'b1;
      hold_off_len = HOLD_OFF_CYCLES;
      repeat (10) send_char(pick_code(), 4'($urandom_range(0, 14)));
   endtask

   // Both sides at full rate to finish.
   task automatic test_full_rate();
      src_gaps    = 1'b0;
      sink_stalls = 1'b0;
      repeat (45) send_char(pick_code(), 4'($urandom_range(0, 14)));
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.char_code <= '0;
      req_ch.slot      <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_glyph_extremes();
      test_random_text();
      test_input_back_pressure();
      test_full_rate();

      // Let the last dot commands drain, then watch for strays.
      req_ch.valid <= 1'b0;
      while (pending_dots.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d characters to the sign and %0d past the message end.",
               n_chars, n_dropped);
      $display("Checked %0d dot commands, %0d of them lit, including a long receiver hold-off.",
               n_dots, n_lit);
      if (n_errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> flipdot_character_dot_commands.f
rtl/fcd_pkg.sv
rtl/fcd_req_if.sv
rtl/fcd_rsp_if.sv
rtl/fcd_ram.sv
rtl/fcd_queue.sv
rtl/fcd_dot_gen.sv
rtl/flipdot_character_dot_commands.sv
rtl/fcd_checker.sv
tb/tb_flipdot_character_dot_commands.sv
